@@ design/clfe_pkg.sv @@
// ----------------------------------------------------------------------------
// clfe_pkg
// Shared types and constants for the cpu load feature extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package clfe_pkg;

  localparam int unsigned InWidth  = 160;
  localparam int unsigned OutWidth = 152;

  localparam logic [10:0] UtilFull    = 11'd1024;
  localparam logic [15:0] CountCap    = 16'hFFFF;
  localparam logic [7:0]  SlopeLimit  = 8'd120;
  localparam logic [6:0]  BoostCap    = 7'd100;
  localparam logic [6:0]  BoostBonus  = 7'd15;
  localparam logic [6:0]  BoostScale  = 7'd100;
  localparam logic [22:0] FrameQ8Num  = 23'd4266496;
  // floor(x * 256 / 10) as (x * 52429) >> 11, exact over the thermal range
  localparam logic [15:0] TenthRecip  = 16'd52429;
  localparam int unsigned DivBits     = 23;
  localparam logic [4:0]  DivFirstBit = 5'(DivBits - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_DONE
  } clfe_state_e;

  typedef struct packed {
    logic load;
    logic calc;
    logic div_step;
    logic out_load;
  } clfe_cmd_t;

  typedef struct packed {
    logic div_last;
  } clfe_status_t;

endpackage

@@ design/clfe_ctrl.sv @@
// ----------------------------------------------------------------------------
// clfe_ctrl
// Sequencer for one sample: latch, update averages, serial divide, hand off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clfe_ctrl
  import clfe_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  clfe_status_t status_i,
  output clfe_cmd_t    cmd_o
);

  clfe_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // output register free once the waiting beat is taken
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ design/clfe_dp.sv @@
// ----------------------------------------------------------------------------
// clfe_dp
// Datapath: averages, slope, prediction, bit-serial frame divider and the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clfe_dp
  import clfe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  clfe_cmd_t           cmd_i,
  output clfe_status_t        status_o,
  input  logic [InWidth-1:0]  in_data_i,
  output logic [OutWidth-1:0] out_data_o
);

  // latched sample
  logic [11:0] util_q;
  logic [31:0] queue_q, wake_q, frame_q, touch_q;
  logic [7:0]  therm_q, bat_q;

  // running state
  logic [11:0] fast_q, slow_q, prev_q;

  // per-sample results
  logic [7:0]  slope_q;
  logic [10:0] pred_q;
  logic [22:0] therm_prod_q;

  // divider
  logic [22:0] rem_q, quot_q;
  logic [4:0]  bit_idx_q;

  logic [OutWidth-1:0] out_q;

  // ---- average, slope and prediction ----
  logic [13:0] fast_sum;
  logic [14:0] slow_sum;
  logic [11:0] fast_new, slow_new;
  logic signed [12:0] diff;
  logic [7:0]  slope_new;
  logic [6:0]  rise;
  logic [12:0] pred_sum;
  logic [10:0] pred_new;
  logic [6:0]  therm_pos;

  always_comb begin
    fast_sum = 14'({fast_q, 1'b0}) + 14'(fast_q) + 14'(util_q);
    slow_sum = 15'({slow_q, 3'b000}) - 15'(slow_q) + 15'(util_q);
    fast_new = fast_sum[13:2];
    slow_new = slow_sum[14:3];
    diff     = $signed({1'b0, util_q}) - $signed({1'b0, prev_q});
    if (diff > $signed(13'(SlopeLimit))) begin
      slope_new = SlopeLimit;
    end else if (diff < -$signed(13'(SlopeLimit))) begin
      slope_new = -SlopeLimit;
    end else begin
      slope_new = diff[7:0];
    end
    rise     = slope_new[7] ? 7'd0 : 7'(slope_new[6:1]);
    pred_sum = 13'(fast_new) + 13'(rise);
    pred_new = (pred_sum > 13'(UtilFull)) ? UtilFull : pred_sum[10:0];
    therm_pos = (therm_q[7] == 1'b0) ? therm_q[6:0] : 7'd0;
  end

  // ---- restoring divider, one quotient bit a cycle ----
  logic [23:0] trial;
  logic        trial_ge;

  always_comb begin
    trial    = {rem_q, FrameQ8Num[bit_idx_q]};
    trial_ge = {8'd0, trial} >= frame_q;
  end

  assign status_o.div_last = (bit_idx_q == 5'd0);

  // ---- output assembly ----
  logic [17:0] boost_prod;
  logic [6:0]  boost_sum, boost;
  logic [10:0] util_cap;
  logic [15:0] queue_cap, wake_cap, touch_cap;
  logic [22:0] ratio;

  always_comb begin
    boost_prod = 18'(pred_q) * 18'(BoostScale);
    boost_sum  = boost_prod[16:10] +
                 (($signed(slope_q) > $signed(8'(BoostBonus))) ? BoostBonus : 7'd0);
    boost      = (boost_sum > BoostCap) ? BoostCap : boost_sum;
    util_cap   = (util_q > 12'(UtilFull)) ? UtilFull : util_q[10:0];
    queue_cap  = (queue_q > 32'(CountCap)) ? CountCap : queue_q[15:0];
    wake_cap   = (wake_q > 32'(CountCap)) ? CountCap : wake_q[15:0];
    touch_cap  = (touch_q > 32'(CountCap)) ? CountCap : touch_q[15:0];
    ratio      = (frame_q == 32'd0) ? 23'd0 : quot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q <= '0;
      slow_q <= '0;
      prev_q <= '0;
    end else if (cmd_i.calc) begin
      fast_q <= fast_new;
      slow_q <= slow_new;
      prev_q <= util_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      util_q  <= in_data_i[11:0];
      queue_q <= in_data_i[43:12];
      wake_q  <= in_data_i[75:44];
      frame_q <= in_data_i[107:76];
      touch_q <= in_data_i[139:108];
      therm_q <= in_data_i[147:140];
      bat_q   <= in_data_i[155:148];
    end
    if (cmd_i.calc) begin
      slope_q      <= slope_new;
      pred_q       <= pred_new;
      therm_prod_q <= 23'(therm_pos) * 23'(TenthRecip);
      rem_q        <= '0;
      quot_q       <= '0;
      bit_idx_q    <= DivFirstBit;
    end
    if (cmd_i.div_step) begin
      rem_q     <= trial_ge ? 23'(trial - frame_q[23:0]) : trial[22:0];
      quot_q    <= {quot_q[21:0], trial_ge};
      bit_idx_q <= bit_idx_q - 5'd1;
    end
    if (cmd_i.out_load) begin
      out_q <= {bat_q, boost, pred_q, slope_q, slow_q, fast_q,
                therm_prod_q[22:11], ratio, touch_cap, wake_cap, queue_cap, util_cap};
    end
  end

  assign out_data_o = out_q;

endmodule

@@ design/cpu_load_feature_extractor.sv @@
// ----------------------------------------------------------------------------
// cpu_load_feature_extractor
// Per-sample load features with fast and slow moving averages of utilisation.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata fields, lowest bit first
//  s_axis   | in        | util_sample, run_queue, wakeup_count, frame_interval,
//           |           | touch_count, therm_headroom, battery_pct
//  m_axis   | out       | util_capped .. battery_out (see port comment)
//
//  A sample passes from accept to result in order: latch, update the averages,
//  run the bit-serial frame ratio divider, then load the output register once
//  that register is free.
//  Reset clears the averages, the previous utilisation, the state and the
//  output valid flag.
//  A result waiting on m_axis does not block the next sample being accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpu_load_feature_extractor
  import clfe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // util_sample[11:0], run_queue[43:12], wakeup_count[75:44], frame_interval[107:76],
  // touch_count[139:108], therm_headroom[147:140], battery_pct[155:148]
  input  logic [InWidth-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // util_capped[10:0], queue_capped[26:11], wakeups_capped[42:27],
  // touches_capped[58:43], frame_ratio[81:59], thermal_feature[93:82],
  // fast_average[105:94], slow_average[117:106], util_slope[125:118],
  // predicted_load[136:126], boost_chance[143:137], battery_out[151:144]
  output logic [OutWidth-1:0] m_axis_tdata_o
);

  clfe_cmd_t    cmd;
  clfe_status_t status;

  clfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  clfe_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (s_axis_tdata_i),
    .out_data_o (m_axis_tdata_o)
  );

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Streams load samples into the feature extractor and checks every result
// beat against a cycle-free model of the averages, slope and Q.8 features.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import clfe_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomSamples = 800;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned ReportLimit = 10;

  // fields from the lowest bit up: util_sample .. battery_pct
  typedef struct packed {
    logic [7:0]  battery_pct;
    logic [7:0]  therm_headroom;
    logic [31:0] touch_count;
    logic [31:0] frame_interval;
    logic [31:0] wakeup_count;
    logic [31:0] run_queue;
    logic [11:0] util_sample;
  } load_sample_t;

  typedef struct packed {
    logic [7:0]  battery_out;
    logic [6:0]  boost_chance;
    logic [10:0] predicted_load;
    logic [7:0]  util_slope;
    logic [11:0] slow_average;
    logic [11:0] fast_average;
    logic [11:0] thermal_feature;
    logic [22:0] frame_ratio;
    logic [15:0] touches_capped;
    logic [15:0] wakeups_capped;
    logic [15:0] queue_capped;
    logic [10:0] util_capped;
  } load_features_t;

  class load_scoreboard;
    logic [11:0] fast_avg;
    logic [11:0] slow_avg;
    logic [11:0] last_util;
    load_features_t pending[$];
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned boosted;

    function new();
      fast_avg = '0;
      slow_avg = '0;
      last_util = '0;
      mismatches = 0;
      results_checked = 0;
      boosted = 0;
    endfunction

    function void note_sample(load_sample_t s);
      load_features_t r;
      int slope;
      int rise;
      int pred;
      int boost;
      int therm;
      fast_avg = 12'((int'(fast_avg) * 3 + int'(s.util_sample)) >> 2);
      slow_avg = 12'((int'(slow_avg) * 7 + int'(s.util_sample)) >> 3);
      slope = int'(s.util_sample) - int'(last_util);
      if (slope > 120) slope = 120;
      if (slope < -120) slope = -120;
      rise = (slope > 0) ? slope / 2 : 0;
      pred = int'(fast_avg) + rise;
      if (pred > 1024) pred = 1024;
      boost = pred * 100 / 1024 + ((slope > 15) ? 15 : 0);
      if (boost > 100) boost = 100;
      if (slope > 15) boosted++;
      last_util = s.util_sample;
      therm = int'($signed(s.therm_headroom));

      r.util_capped    = (s.util_sample > 12'd1024) ? 11'd1024 : s.util_sample[10:0];
      r.queue_capped   = (s.run_queue > 32'hFFFF) ? 16'hFFFF : s.run_queue[15:0];
      r.wakeups_capped = (s.wakeup_count > 32'hFFFF) ? 16'hFFFF : s.wakeup_count[15:0];
      r.touches_capped = (s.touch_count > 32'hFFFF) ? 16'hFFFF : s.touch_count[15:0];
      r.frame_ratio    = (s.frame_interval != 0) ? 23'(32'd4266496 / s.frame_interval) : '0;
      r.thermal_feature = (therm > 0) ? 12'(therm * 256 / 10) : '0;
      r.fast_average   = fast_avg;
      r.slow_average   = slow_avg;
      r.util_slope     = 8'(slope);
      r.predicted_load = 11'(pred);
      r.boost_chance   = 7'(boost);
      r.battery_out    = s.battery_pct;
      pending.push_back(r);
    endfunction

    function void check_result(logic [OutWidth-1:0] beat);
      int unsigned widths[12] = '{11, 16, 16, 16, 23, 12, 12, 12, 8, 11, 7, 8};
      string names[12] = '{"util_capped", "queue_capped", "wakeups_capped",
                           "touches_capped", "frame_ratio", "thermal_feature",
                           "fast_average", "slow_average", "util_slope",
                           "predicted_load", "boost_chance", "battery_out"};
      logic [OutWidth-1:0] want;
      logic [31:0] want_f;
      logic [31:0] got_f;
      int unsigned lsb;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("[%0t] result beat with nothing expected: %h", $realtime, beat);
        return;
      end
      want = pending.pop_front();
      results_checked++;
      lsb = 0;
      for (int i = 0; i < 12; i++) begin
        want_f = 32'(want >> lsb) & ((32'd1 << widths[i]) - 1);
        got_f = 32'(beat >> lsb) & ((32'd1 << widths[i]) - 1);
        if (want_f !== got_f) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("[%0t] result %0d %s: expected %0d, got %0d", $realtime,
                     results_checked, names[i], want_f, got_f);
        end
        lsb += widths[i];
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InWidth-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutWidth-1:0] m_axis_tdata;

  load_scoreboard feature_sb;
  int unsigned cycle_count = 0;
  int unsigned samples_sent = 0;
  int unsigned zero_frames = 0;
  logic [11:0] recent_util = '0;

  int unsigned rx_cycle = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_hold = 0;

  cpu_load_feature_extractor u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timed out after %0d cycles", cycle_count);
      $display("cpu_load_feature_extractor test failed");
      $finish;
    end
  end

  // receiver: stall style switches at random among four modes
  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 500 == 0) rx_mode = $urandom_range(0, 3);
    if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: begin
          if ($urandom_range(0, 3) == 0) begin
            rx_hold = $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
          end else begin
            m_axis_tready <= 1'b1;
          end
        end
        2: begin
          if ($urandom_range(0, 7) == 0) begin
            rx_hold = $urandom_range(5, 40);
            m_axis_tready <= 1'b0;
          end else begin
            m_axis_tready <= 1'b1;
          end
        end
        default: m_axis_tready <= (rx_cycle % 7) < 3;
      endcase
    end
  end

  // inputs only move at rising edges, so the falling edge sees the settled beat
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) feature_sb.check_result(m_axis_tdata);
  end

  function automatic load_sample_t mk_sample(logic [11:0] util, logic [31:0] queue,
                                             logic [31:0] wakes, logic [31:0] frame,
                                             logic [31:0] touches, logic [7:0] therm,
                                             logic [7:0] battery);
    load_sample_t s;
    s.util_sample = util;
    s.run_queue = queue;
    s.wakeup_count = wakes;
    s.frame_interval = frame;
    s.touch_count = touches;
    s.therm_headroom = therm;
    s.battery_pct = battery;
    return s;
  endfunction

  // called at a rising edge, returns at the edge where the beat is taken
  task automatic send_sample(load_sample_t s);
    logic ready;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= InWidth'(s);
    do begin
      @(negedge clk_i);
      ready = s_axis_tready;
      if (ready) begin
        feature_sb.note_sample(s);
        samples_sent++;
        if (s.frame_interval == 0) zero_frames++;
      end
      @(posedge clk_i);
    end while (!ready);
    recent_util = s.util_sample;
  endtask

  task automatic idle_gap(int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic run_directed();
    send_sample(mk_sample(12'd0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0, 8'd0));
    send_sample(mk_sample(12'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1,
                          32'hFFFF_FFFF, 8'sd127, 8'd255));
    send_sample(mk_sample(12'd4095, 32'd65535, 32'd65536, 32'hFFFF_FFFF,
                          32'd65535, 8'h80, 8'd100));
    // sharp fall clamps the slope at its negative limit
    send_sample(mk_sample(12'd0, 32'd65536, 32'd65535, 32'd4266496,
                          32'd65536, 8'hFF, 8'd1));
    send_sample(mk_sample(12'd1024, 32'd1, 32'd1, 32'd4266497, 32'd1, 8'sd1, 8'd50));
    send_sample(mk_sample(12'd1025, 32'd3, 32'd17, 32'd16666, 32'd2, 8'sd10, 8'd80));
    send_sample(mk_sample(12'd1025, 32'd4, 32'd9, 32'd8333, 32'd5, 8'sd9, 8'd81));
    send_sample(mk_sample(12'd500, 32'd2, 32'd7, 32'd33333, 32'd0, 8'sd25, 8'd82));
    // slope right at the boost threshold, then one above
    send_sample(mk_sample(12'd515, 32'd2, 32'd7, 32'd33333, 32'd0, 8'sd25, 8'd82));
    send_sample(mk_sample(12'd531, 32'd2, 32'd7, 32'd16667, 32'd3, 8'sd26, 8'd83));
    send_sample(mk_sample(12'd651, 32'd5, 32'd8, 32'd11111, 32'd3, 8'sd40, 8'd84));
    send_sample(mk_sample(12'd772, 32'd6, 32'd8, 32'd2, 32'd4, 8'sd60, 8'd85));
    send_sample(mk_sample(12'd772, 32'd6, 32'd8, 32'd3, 32'd4, 8'sd0, 8'd86));
    send_sample(mk_sample(12'd700, 32'd7, 32'd9, 32'd0, 32'd4, 8'hF6, 8'd87));
    send_sample(mk_sample(12'd1024, 32'd8, 32'd9, 32'd100, 32'd4, 8'sd100, 8'd88));
    send_sample(mk_sample(12'd1024, 32'd8, 32'd9, 32'd200, 32'd4, 8'sd127, 8'd89));
    send_sample(mk_sample(12'd2048, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                          32'h5555_5555, 8'hAA, 8'hAA));
    send_sample(mk_sample(12'd2730, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                          32'hAAAA_AAAA, 8'h55, 8'h55));
    idle_gap(3);
  endtask

  function automatic logic [31:0] rand_count();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 100);
      1: return $urandom_range(65530, 65540);
      2: return $urandom_range(0, 70000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_frame();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1, 2: return $urandom_range(1, 64);
      3, 4, 5, 6: return $urandom_range(8000, 50000);
      7: return $urandom_range(4266490, 4266500);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [11:0] rand_util(logic [11:0] prev);
    int u;
    case ($urandom_range(0, 7))
      0, 1, 2: return 12'($urandom_range(0, 1100));
      3, 4: begin
        u = int'(prev) + int'($urandom_range(0, 80)) - 40;
        if (u < 0) u = 0;
        if (u > 4095) u = 4095;
        return 12'(u);
      end
      5: return 12'($urandom_range(0, 4095));
      default: begin
        case ($urandom_range(0, 3))
          0: return 12'd0;
          1: return 12'd1024;
          2: return 12'd4095;
          default: return 12'(int'(prev) + 16);
        endcase
      end
    endcase
  endfunction

  task automatic run_random();
    int unsigned left;
    int unsigned burst;
    load_sample_t s;
    left = RandomSamples;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      if (burst > left) burst = left;
      repeat (burst) begin
        s.util_sample = rand_util(recent_util);
        s.run_queue = rand_count();
        s.wakeup_count = rand_count();
        s.frame_interval = rand_frame();
        s.touch_count = rand_count();
        s.therm_headroom = 8'($urandom_range(0, 255));
        s.battery_pct = 8'($urandom_range(0, 255));
        send_sample(s);
      end
      left -= burst;
      if ($urandom_range(0, 9) < 6) idle_gap($urandom_range(1, 40));
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    feature_sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    while (feature_sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("%0d samples sent, %0d results checked, %0d with a boost-sized rise,",
             samples_sent, feature_sb.results_checked, feature_sb.boosted);
    $display("%0d with no frame interval, %0d field mismatches",
             zero_frames, feature_sb.mismatches);
    if (feature_sb.mismatches == 0 && feature_sb.pending.size() == 0) begin
      $display("cpu_load_feature_extractor test passed");
    end else begin
      $display("cpu_load_feature_extractor test failed");
    end
    $finish;
  end

endmodule
